[sv/rau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPC_W  = 4;
	localparam int NUM_W  = 32;
	localparam int DEN_W  = 31;
	localparam int ST_W   = 2;
	localparam int PROD_W = 2 * NUM_W;
	localparam int CNT_W  = $clog2(PROD_W);
	localparam int SHF_W  = $clog2(PROD_W);

	localparam logic [OPC_W-1:0] OP_ADD  = 4'd0;
	localparam logic [OPC_W-1:0] OP_SUB  = 4'd1;
	localparam logic [OPC_W-1:0] OP_MUL  = 4'd2;
	localparam logic [OPC_W-1:0] OP_DIV  = 4'd3;
	localparam logic [OPC_W-1:0] OP_NEG  = 4'd4;
	localparam logic [OPC_W-1:0] OP_LT   = 4'd5;
	localparam logic [OPC_W-1:0] OP_GT   = 4'd6;
	localparam logic [OPC_W-1:0] OP_EQ   = 4'd7;
	localparam logic [OPC_W-1:0] OP_NORM = 4'd8;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_ZDEN = 2'd1;
	localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

	// multiplier operand selection
	localparam logic [1:0] MS_AN_BD = 2'd0;
	localparam logic [1:0] MS_BN_AD = 2'd1;
	localparam logic [1:0] MS_AD_BD = 2'd2;
	localparam logic [1:0] MS_AN_BN = 2'd3;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       form;
		logic       gcd_step;
		logic       div_load;
		logic       div_sel;
		logic       div_step;
		logic       fin;
	} rau_cmd_t;

	typedef struct packed {
		logic early;
		logic is_cmp;
		logic gcd_done;
	} rau_sts_t;

endpackage
`default_nettype wire

[sv/rau_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: products, gcd loop, two long divisions, output register
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_stall,
	input  wire rau_pkg::rau_sts_t sts,
	output logic                   in_stall,
	output logic                   out_valid,
	output rau_pkg::rau_cmd_t      cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_FORM  = 8'b0000_0100,
		S_GCD   = 8'b0000_1000,
		S_DIVN  = 8'b0001_0000,
		S_LOADD = 8'b0010_0000,
		S_DIVD  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t                      state_q, state_d;
	logic [rau_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                        out_valid_q, out_valid_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				if (sts.early) begin
					state_d = S_DONE;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = cnt_q[1:0];
					cnt_d       = cnt_q + 1'b1;
					if (cnt_q[1:0] == rau_pkg::MS_AN_BN) begin
						cnt_d   = '0;
						state_d = S_FORM;
					end
				end
			end
			S_FORM: begin
				cmd.form = 1'b1;
				state_d  = sts.is_cmp ? S_DONE : S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_load = 1'b1;
					cmd.div_sel  = 1'b0;
					cnt_d        = '0;
					state_d      = S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == '1) begin
					state_d = S_LOADD;
				end
			end
			S_LOADD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIVD;
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == '1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.fin) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[sv/rau_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_dpath
// operand registers, shared multiplier, binary gcd, restoring divider
// ----------------------------------------------------------------------------
module rau_dpath #(
	parameter int WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire rau_pkg::rau_cmd_t             cmd,
	input  wire logic [rau_pkg::OPC_W-1:0]     op,
	input  wire logic signed [rau_pkg::NUM_W-1:0] a_num,
	input  wire logic signed [rau_pkg::NUM_W-1:0] a_den,
	input  wire logic signed [rau_pkg::NUM_W-1:0] b_num,
	input  wire logic signed [rau_pkg::NUM_W-1:0] b_den,
	output rau_pkg::rau_sts_t                  sts,
	output logic signed [rau_pkg::NUM_W-1:0]   res_num,
	output logic [rau_pkg::DEN_W-1:0]          res_den,
	output logic                               compare_true,
	output logic [rau_pkg::ST_W-1:0]           status
);

	localparam int NW = rau_pkg::NUM_W;
	localparam int PW = rau_pkg::PROD_W;
	localparam logic [PW-1:0] LIM = {{(PW-1){1'b0}}, 1'b1} << (WIDTH - 1);

	function automatic logic [NW-1:0] mag32(input logic [NW-1:0] v);
		return v[NW-1] ? (~v + 1'b1) : v;
	endfunction

	logic [rau_pkg::OPC_W-1:0] op_q;
	logic [NW-1:0]             an_q, ad_q, bn_q, bd_q;
	logic [PW-1:0]             p1_q, p2_q, p3_q, p4_q;
	logic [PW-1:0]             rm_q, rd_q;
	logic                      rn_q, cmp_q;
	logic [PW-1:0]             u_q, v_q;
	logic [rau_pkg::SHF_W-1:0] k_q;
	logic [PW-1:0]             rem_q, dvd_q, dsr_q, qn_q;
	logic signed [NW-1:0]      res_num_q;
	logic [rau_pkg::DEN_W-1:0] res_den_q;
	logic                      cmp_out_q;
	logic [rau_pkg::ST_W-1:0]  status_q;

	logic [NW-1:0] an_m, ad_m, bn_m, bd_m;
	logic          a_neg, b_neg, bad_op, one_opnd, zden, is_cmp;

	assign an_m     = mag32(an_q);
	assign ad_m     = mag32(ad_q);
	assign bn_m     = mag32(bn_q);
	assign bd_m     = mag32(bd_q);
	assign a_neg    = an_q[NW-1] ^ ad_q[NW-1];
	assign b_neg    = bn_q[NW-1] ^ bd_q[NW-1];
	assign bad_op   = (op_q > rau_pkg::OP_NORM);
	assign one_opnd = (op_q == rau_pkg::OP_NEG) || (op_q == rau_pkg::OP_NORM);
	assign zden     = (ad_q == '0) || (!one_opnd && (bd_q == '0))
			|| ((op_q == rau_pkg::OP_DIV) && (bn_q == '0));
	assign is_cmp   = (op_q == rau_pkg::OP_LT) || (op_q == rau_pkg::OP_GT)
			|| (op_q == rau_pkg::OP_EQ);

	assign sts.early    = bad_op || zden;
	assign sts.is_cmp   = is_cmp;
	assign sts.gcd_done = (u_q == '0);

	// shared multiplier
	logic [NW-1:0] mx, my;
	logic [PW-1:0] prod;
	always_comb begin
		unique case (cmd.mul_sel)
			rau_pkg::MS_AN_BD: begin mx = an_m; my = bd_m; end
			rau_pkg::MS_BN_AD: begin mx = bn_m; my = ad_m; end
			rau_pkg::MS_AD_BD: begin mx = ad_m; my = bd_m; end
			default:           begin mx = an_m; my = bn_m; end
		endcase
	end
	assign prod = PW'(mx) * PW'(my);

	// fraction forming and compare
	logic [PW-1:0]        rm_n, rd_n;
	logic                 rn_n, t2_neg, cmp_n;
	logic signed [PW-1:0] lx, gx;
	assign t2_neg = b_neg ^ (op_q == rau_pkg::OP_SUB);
	always_comb begin
		rm_n = p1_q;
		rd_n = p3_q;
		rn_n = a_neg;
		case (op_q) inside
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				if (a_neg == t2_neg) begin
					rm_n = p1_q + p2_q;
				end else if (p1_q >= p2_q) begin
					rm_n = p1_q - p2_q;
				end else begin
					rm_n = p2_q - p1_q;
					rn_n = t2_neg;
				end
			end
			rau_pkg::OP_MUL: begin
				rm_n = p4_q;
				rn_n = a_neg ^ b_neg;
			end
			rau_pkg::OP_DIV: begin
				rd_n = p2_q;
				rn_n = a_neg ^ b_neg;
			end
			rau_pkg::OP_NEG: begin
				rm_n = PW'(an_m);
				rd_n = PW'(ad_m);
				rn_n = !a_neg;
			end
			default: begin
				rm_n = PW'(an_m);
				rd_n = PW'(ad_m);
			end
		endcase
	end
	assign lx = a_neg ? -$signed(p1_q) : $signed(p1_q);
	assign gx = b_neg ? -$signed(p2_q) : $signed(p2_q);
	always_comb begin
		case (op_q)
			rau_pkg::OP_LT: cmp_n = (lx < gx);
			rau_pkg::OP_GT: cmp_n = (lx > gx);
			default:        cmp_n = (lx == gx);
		endcase
	end

	// divider step
	logic [PW:0] rem_sh, rem_sub;
	assign rem_sh  = {rem_q, dvd_q[PW-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	// final result
	logic          fneg, ovf;
	logic [PW-1:0] qd;
	assign qd   = dvd_q;
	assign fneg = rn_q && (qn_q != '0);
	assign ovf  = (fneg ? (qn_q > LIM) : (qn_q > LIM - 1'b1)) || (qd > LIM - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			an_q <= a_num;
			ad_q <= a_den;
			bn_q <= b_num;
			bd_q <= b_den;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				rau_pkg::MS_AN_BD: p1_q <= prod;
				rau_pkg::MS_BN_AD: p2_q <= prod;
				rau_pkg::MS_AD_BD: p3_q <= prod;
				default:           p4_q <= prod;
			endcase
		end
		if (cmd.form) begin
			rm_q  <= rm_n;
			rd_q  <= rd_n;
			rn_q  <= rn_n;
			cmp_q <= cmp_n;
			u_q   <= rm_n;
			v_q   <= rd_n;
			k_q   <= '0;
		end else if (cmd.gcd_step && (u_q != '0)) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			if (cmd.div_sel) begin
				qn_q  <= dvd_q;
				dvd_q <= rd_q;
			end else begin
				dsr_q <= v_q << k_q;
				dvd_q <= rm_q;
			end
		end else if (cmd.div_step) begin
			if (!rem_sub[PW]) begin
				rem_q <= rem_sub[PW-1:0];
				dvd_q <= {dvd_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[PW-1:0];
				dvd_q <= {dvd_q[PW-2:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			res_num_q <= '0;
			res_den_q <= '0;
			cmp_out_q <= 1'b0;
			status_q  <= rau_pkg::ST_OK;
			if (bad_op) begin
				status_q <= rau_pkg::ST_OK;
			end else if (zden) begin
				status_q <= rau_pkg::ST_ZDEN;
			end else if (is_cmp) begin
				cmp_out_q <= cmp_q;
			end else if (ovf) begin
				status_q <= rau_pkg::ST_OVF;
			end else begin
				res_num_q <= fneg ? -$signed(qn_q[NW-1:0]) : $signed(qn_q[NW-1:0]);
				res_den_q <= qd[rau_pkg::DEN_W-1:0];
			end
		end
	end

	assign res_num      = res_num_q;
	assign res_den      = res_den_q;
	assign compare_true = cmp_out_q;
	assign status       = status_q;

endmodule
`default_nettype wire

[sv/rational_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// work: rejected requests skip all steps, compares skip the gcd loop and the divisions;
//   fraction results go through the binary gcd loop (one step a cycle, up to about
//   128 steps) and the two 64-step restoring divisions
// throughput: one request at a time; a new request is taken while the previous
//   result still waits in the output register
// reset: arst_n clears the sequencer and the output valid asynchronously
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// exact add, sub, mul, div, negate, normalize and compare of two fractions
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
	parameter int WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [rau_pkg::OPC_W-1:0]        op,
	input  wire logic signed [rau_pkg::NUM_W-1:0] a_num,
	input  wire logic signed [rau_pkg::NUM_W-1:0] a_den,
	input  wire logic signed [rau_pkg::NUM_W-1:0] b_num,
	input  wire logic signed [rau_pkg::NUM_W-1:0] b_den,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [rau_pkg::NUM_W-1:0]      res_num,
	output logic [rau_pkg::DEN_W-1:0]             res_den,
	output logic                                  compare_true,
	output logic [rau_pkg::ST_W-1:0]              status
);

	// command and status between sequencer and datapath
	rau_pkg::rau_cmd_t cmd;
	rau_pkg::rau_sts_t sts;

	// sequencer: takes a request in idle, walks the products, the gcd loop and
	// both divisions (compares, rejected requests stop early), then loads the output register once it is free
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// datapath: operands, one 32x32 multiplier, gcd registers, divider
	rau_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.op           (op),
		.a_num        (a_num),
		.a_den        (a_den),
		.b_num        (b_num),
		.b_den        (b_den),
		.sts          (sts),
		.res_num      (res_num),
		.res_den      (res_den),
		.compare_true (compare_true),
		.status       (status)
	);

	// a taken request keeps the unit busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken but unit not busy");

	// a true compare result carries no fraction and no error
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && compare_true) |-> (status == rau_pkg::ST_OK && res_den == '0
			&& res_num == '0))
		else $error("compare result with fraction or error");

	// an error result is all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != rau_pkg::ST_OK) |-> (res_num == '0 && res_den == '0
			&& !compare_true))
		else $error("error result not cleared");

	// a result register is only loaded while the unit is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the rational arithmetic unit against an exact fraction predictor,
// with random idling on both channels and a long stretch without idling
// ----------------------------------------------------------------------------
module tb;

	localparam int OW = rau_pkg::OPC_W;
	localparam int NW = rau_pkg::NUM_W;
	localparam int DW = rau_pkg::DEN_W;
	localparam int SW = rau_pkg::ST_W;

	typedef struct {
		logic [OW-1:0] op;
		logic [31:0]   an, ad, bn, bd;
	} request_t;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic        cmp;
		logic [1:0]  st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OW-1:0] op = '0;
	logic signed [NW-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [NW-1:0] res_num;
	logic [DW-1:0] res_den;
	logic compare_true;
	logic [SW-1:0] status;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	bit       failed = 1'b0;
	bit       quiet = 1'b0;   // no idling at all while set
	bit       stim_done = 1'b0;

	rational_arithmetic_unit_top #(.WIDTH(32)) uut (.*);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// bring a signed fraction to lowest terms, sign on the magnitude flag
	function automatic void lowest(input bit ng, input longint unsigned m,
			input longint unsigned d, output bit rng, output longint unsigned rm,
			output longint unsigned rd);
		longint unsigned g;
		g = gcd64(m, d);
		rm = m / g;
		rd = d / g;
		rng = (rm != 0) && ng;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// exact fraction arithmetic of one request
	function automatic answer_t rational_result(request_t rq);
		answer_t r;
		longint an, ad, bn, bd, l, g;
		bit a_ng, b_ng, rn, fn, t;
		longint unsigned am, adn, bm, bdn, rm, rd, fm, fd, lim, x, y;
		r = '{default: '0};
		an = longint'($signed(rq.an)); ad = longint'($signed(rq.ad));
		bn = longint'($signed(rq.bn)); bd = longint'($signed(rq.bd));
		lim = 64'd1 << 31;
		if (rq.op > rau_pkg::OP_NORM) return r;
		if (ad == 0 || (rq.op != rau_pkg::OP_NEG && rq.op != rau_pkg::OP_NORM
				&& bd == 0)) begin
			r.st = rau_pkg::ST_ZDEN;
			return r;
		end
		lowest((an < 0) != (ad < 0), mag(an), mag(ad), a_ng, am, adn);
		if (rq.op != rau_pkg::OP_NEG && rq.op != rau_pkg::OP_NORM)
			lowest((bn < 0) != (bd < 0), mag(bn), mag(bd), b_ng, bm, bdn);
		else begin
			b_ng = a_ng; bm = am; bdn = adn;
		end
		if (rq.op == rau_pkg::OP_LT || rq.op == rau_pkg::OP_GT
				|| rq.op == rau_pkg::OP_EQ) begin
			l = longint'(am * bdn); if (a_ng) l = -l;
			g = longint'(bm * adn); if (b_ng) g = -g;
			t = rq.op == rau_pkg::OP_LT ? l < g : rq.op == rau_pkg::OP_GT ? l > g : l == g;
			r.cmp = t;
			return r;
		end
		case (rq.op)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				// signed-magnitude sum of the cross products
				x = am * bdn;
				y = bm * adn;
				if (rq.op == rau_pkg::OP_SUB) b_ng = !b_ng;
				if (a_ng == b_ng) begin rn = a_ng; rm = x + y; end
				else if (x >= y) begin rn = a_ng; rm = x - y; end
				else begin rn = b_ng; rm = y - x; end
				rd = adn * bdn;
			end
			rau_pkg::OP_MUL: begin rn = a_ng != b_ng; rm = am * bm; rd = adn * bdn; end
			rau_pkg::OP_DIV: begin
				if (bm == 0) begin r.st = rau_pkg::ST_ZDEN; return r; end
				rn = a_ng != b_ng; rm = am * bdn; rd = adn * bm;
			end
			rau_pkg::OP_NEG: begin rn = !a_ng; rm = am; rd = adn; end
			default: begin rn = a_ng; rm = am; rd = adn; end
		endcase
		lowest(rn, rm, rd, fn, fm, fd);
		if ((fn ? fm > lim : fm > lim - 1) || fd > lim - 1) begin
			r.st = rau_pkg::ST_OVF;
			return r;
		end
		r.num = fn ? 32'(-longint'(fm)) : 32'(fm);
		r.den = 31'(fd);
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(0, 6)) - 3);
			3, 4, 5: return 32'(int'($urandom_range(0, 200)) - 100);
			6: return 32'(int'($urandom_range(0, 100000)) - 50000);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(logic [OW-1:0] o, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		request_t rq;
		rq.op = o; rq.an = an; rq.ad = ad; rq.bn = bn; rq.bd = bd;
		pending_reqs.insert(pending_reqs.size(), rq);
	endtask

	// stimulus
	initial begin
		// every op on small values, then the corner cases
		for (int o = 0; o <= 8; o++) add_req(o[OW-1:0], 6, -4, -3, 9);
		add_req(rau_pkg::OP_ADD, 1, 0, 1, 1);              // zero denominator in a
		add_req(rau_pkg::OP_MUL, 1, 1, 1, 0);              // zero denominator in b
		add_req(rau_pkg::OP_NEG, 5, 3, 0, 0);              // b ignored for negate
		add_req(rau_pkg::OP_DIV, 3, 4, 0, 7);              // division by zero
		add_req(rau_pkg::OP_NEG, 32'h8000_0000, 1, 1, 1);  // negate overflows
		add_req(rau_pkg::OP_NORM, 32'h8000_0000, -1, 1, 1); // normalize overflows
		add_req(rau_pkg::OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 1);
		add_req(rau_pkg::OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		add_req(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		add_req(rau_pkg::OP_SUB, 32'h8000_0000, 1, 32'h8000_0000, 1); // zero result
		add_req(rau_pkg::OP_DIV, 1, 32'h7fff_ffff, 32'h7fff_ffff, 1);
		add_req(rau_pkg::OP_EQ, 2, 4, -1, -2);
		add_req(rau_pkg::OP_LT, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000);
		add_req(rau_pkg::OP_GT, 0, -5, 0, 3);
		add_req(4'd15, -1, -1, -1, -1);                    // unused op code
		add_req(4'd9, 1, 1, 1, 1);
		for (int i = 0; i < 900; i++) begin
			logic [OW-1:0] o;
			o = ($urandom_range(0, 19) == 0) ? OW'($urandom_range(9, 15))
				: OW'($urandom_range(0, 8));
			add_req(o, pick_word(), pick_word(), pick_word(), pick_word());
		end
	end

	// reset held from time zero, then released
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver
	always @(posedge clk) begin
		request_t rq;
		if (in_valid && !in_stall) begin
			expected_answers.insert(expected_answers.size(), rational_result(
				'{op: op, an: a_num, ad: a_den, bn: b_num, bd: b_den}));
		end
		if (arst_n && (!in_valid || !in_stall)) begin
			if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 29)) begin
				rq = pending_reqs.pop_front();
				op <= rq.op; a_num <= rq.an; a_den <= rq.ad;
				b_num <= rq.bn; b_den <= rq.bd;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (pending_reqs.size() == 0) stim_done <= 1'b1;
			end
		end
	end

	// quiet stretch somewhere in the middle of the random part
	always @(posedge clk) begin
		if (pending_reqs.size() == 500) quiet <= 1'b1;
		else if (pending_reqs.size() == 350) quiet <= 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		answer_t e;
		out_stall <= !quiet && $urandom_range(0, 99) < 29;
		if (out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: result with nothing expected: num %0d den %0d cmp %0b st %0d",
					$time, res_num, res_den, compare_true, status);
				failed = 1'b1;
			end else begin
				e = expected_answers.pop_front();
				if (res_num !== e.num || res_den !== e.den || compare_true !== e.cmp
						|| status !== e.st) begin
					$display("%0t: expected num %0d den %0d cmp %0b st %0d, got %0d %0d %0b %0d",
						$time, $signed(e.num), e.den, e.cmp, e.st,
						res_num, res_den, compare_true, status);
					failed = 1'b1;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (!in_valid && expected_answers.size() == 0);
		repeat (400) @(posedge clk);
		if (!failed && expected_answers.size() == 0)
			$display("rational_arithmetic_unit_top: match");
		else
			$display("rational_arithmetic_unit_top: mismatch");
		$finish;
	end

	// timeout: room for ~930 requests at the worst latency plus idling and stalls
	initial begin
		#20_000_000;
		$display("rational_arithmetic_unit_top: mismatch");
		$finish;
	end

endmodule
